// File: rtl/core/nnsa_pkg.sv
package nnsa_pkg;

    // Largest image side in pixels
    localparam int MAX_DIM   = 2048;
    localparam int SIZE_W    = 12;
    localparam int COORD_W   = 11;
    localparam int PROD_W    = COORD_W + SIZE_W;
    localparam int LIN_W     = 22;
    localparam int ADDR_W    = 24;
    localparam int CFG_IDX_W = 8;
    // One restoring step per quotient bit
    localparam int DIV_STEPS = COORD_W;

    // Register reset values
    localparam logic [SIZE_W-1:0] RST_SRC_WIDTH   = SIZE_W'(800);
    localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT  = SIZE_W'(480);
    localparam logic [SIZE_W-1:0] RST_DEST_WIDTH  = SIZE_W'(800);
    localparam logic [SIZE_W-1:0] RST_DEST_HEIGHT = SIZE_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH   = CFG_IDX_W'(0),
        REG_SRC_HEIGHT  = CFG_IDX_W'(1),
        REG_DEST_WIDTH  = CFG_IDX_W'(2),
        REG_DEST_HEIGHT = CFG_IDX_W'(3)
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] dest_col;
        logic [COORD_W-1:0] dest_row;
    } in_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] src_row;
        logic [ADDR_W-1:0]  src_byte_addr;
        logic [ADDR_W-1:0]  dest_byte_addr;
    } out_word_t;

    // One divider lane: partial remainder, and a word that starts as the
    // low numerator bits and fills with quotient bits from the right
    typedef struct packed {
        logic [COORD_W-1:0] rem;
        logic [COORD_W-1:0] work;
    } lane_t;

    typedef struct packed {
        lane_t             col;
        lane_t             row;
        logic [LIN_W-1:0]  dest_lin;
    } cell_word_t;

    // Clamp a size register to 1..MAX_DIM
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] s;
        s = v;
        if (v == '0) begin
            s = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_DIM)) begin
            s = SIZE_W'(MAX_DIM);
        end
        return s;
    endfunction

endpackage

// File: rtl/core/nnsa_div_cell.sv
module nnsa_div_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [nnsa_pkg::SIZE_W-1:0]  div_col,
    input  logic [nnsa_pkg::SIZE_W-1:0]  div_row,
    input  logic                         up_valid,
    input  nnsa_pkg::cell_word_t         up_data,
    output logic                         up_ready,
    output logic                         dn_valid,
    output nnsa_pkg::cell_word_t         dn_data,
    input  logic                         dn_ready
);
    import nnsa_pkg::*;

    logic       valid_reg, valid_next;
    cell_word_t data_reg, data_next;

    // One restoring division step on a lane
    function automatic lane_t div_step(input lane_t l, input logic [SIZE_W-1:0] d);
        logic [SIZE_W-1:0] t;
        logic [SIZE_W-1:0] diff;
        logic              ge;
        lane_t             r;
        t    = {l.rem, l.work[COORD_W-1]};
        ge   = (t >= d);
        diff = t - d;
        r.rem  = ge ? diff[COORD_W-1:0] : t[COORD_W-1:0];
        r.work = {l.work[COORD_W-2:0], ge};
        return r;
    endfunction

    // Hold while full and the neighbor is stalled
    assign up_ready = !valid_reg || dn_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (up_ready) begin
            valid_next         = up_valid;
            data_next.col      = div_step(up_data.col, div_col);
            data_next.row      = div_step(up_data.row, div_row);
            data_next.dest_lin = up_data.dest_lin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: rtl/core/nearest_neighbor_scale_address.sv
// Throughput: one word per cycle while the output is not stalled. Stages, in order:
// saturate, multiply, eleven divider cells (one quotient bit each), source address
// and output, each a register.
// Each stage holds under output stall; bubbles are squeezed out.
// Reset (synchronous, aresetn low): pipeline emptied, sizes set to
// 800x480 source and 800x480 destination.
module nearest_neighbor_scale_address (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nnsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnsa_pkg::SIZE_W-1:0]     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  nnsa_pkg::in_word_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output nnsa_pkg::out_word_t             m_data
);
    import nnsa_pkg::*;

    // Effective (clamped) sizes
    logic [SIZE_W-1:0] sw_reg, sh_reg, dw_reg, dh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg <= RST_SRC_WIDTH;
            sh_reg <= RST_SRC_HEIGHT;
            dw_reg <= RST_DEST_WIDTH;
            dh_reg <= RST_DEST_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                REG_SRC_WIDTH:   sw_reg <= eff_size(cfg_data);
                REG_SRC_HEIGHT:  sh_reg <= eff_size(cfg_data);
                REG_DEST_WIDTH:  dw_reg <= eff_size(cfg_data);
                REG_DEST_HEIGHT: dh_reg <= eff_size(cfg_data);
                default: ;
            endcase
        end
    end

    // Stage A: saturate coordinates into the destination image
    logic               a_valid_reg, a_ready;
    logic [COORD_W-1:0] a_col_reg, a_row_reg;
    logic [SIZE_W-1:0]  dw_m1, dh_m1;
    logic               b_ready;

    assign dw_m1   = dw_reg - SIZE_W'(1);
    assign dh_m1   = dh_reg - SIZE_W'(1);
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_valid;
        end
        if (a_ready) begin
            a_col_reg <= ({1'b0, s_data.dest_col} >= dw_reg) ? dw_m1[COORD_W-1:0]
                                                              : s_data.dest_col;
            a_row_reg <= ({1'b0, s_data.dest_row} >= dh_reg) ? dh_m1[COORD_W-1:0]
                                                              : s_data.dest_row;
        end
    end

    // Stage B: numerators and destination linear index
    logic               b_valid_reg;
    cell_word_t         b_data_reg;
    logic [PROD_W-1:0]  col_prod, row_prod, dlin_prod;
    logic               cell_valid [0:DIV_STEPS];
    logic               cell_ready [0:DIV_STEPS];
    cell_word_t         cell_data  [0:DIV_STEPS];

    assign col_prod  = a_col_reg * sw_reg;
    assign row_prod  = a_row_reg * sh_reg;
    assign dlin_prod = a_row_reg * dw_reg + PROD_W'(a_col_reg);
    assign b_ready   = !b_valid_reg || cell_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
        if (b_ready) begin
            b_data_reg.col.rem  <= col_prod[LIN_W-1:COORD_W];
            b_data_reg.col.work <= col_prod[COORD_W-1:0];
            b_data_reg.row.rem  <= row_prod[LIN_W-1:COORD_W];
            b_data_reg.row.work <= row_prod[COORD_W-1:0];
            b_data_reg.dest_lin <= dlin_prod[LIN_W-1:0];
        end
    end

    assign cell_valid[0] = b_valid_reg;
    assign cell_data[0]  = b_data_reg;

    // Divider chain
    logic c_ready;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        nnsa_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .div_col  (dw_reg),
            .div_row  (dh_reg),
            .up_valid (cell_valid[k]),
            .up_data  (cell_data[k]),
            .up_ready (cell_ready[k]),
            .dn_valid (cell_valid[k+1]),
            .dn_data  (cell_data[k+1]),
            .dn_ready (cell_ready[k+1])
        );
    end

    assign cell_ready[DIV_STEPS] = c_ready;

    // Stage C: source linear index
    logic               c_valid_reg;
    logic [COORD_W-1:0] c_sc_reg, c_sr_reg;
    logic [LIN_W-1:0]   c_slin_reg, c_dlin_reg;
    logic [PROD_W-1:0]  slin_prod;
    logic               d_ready;
    cell_word_t         last;

    assign last      = cell_data[DIV_STEPS];
    assign slin_prod = last.row.work * sw_reg + PROD_W'(last.col.work);
    assign c_ready   = !c_valid_reg || d_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= cell_valid[DIV_STEPS];
        end
        if (c_ready) begin
            c_sc_reg   <= last.col.work;
            c_sr_reg   <= last.row.work;
            c_slin_reg <= slin_prod[LIN_W-1:0];
            c_dlin_reg <= last.dest_lin;
        end
    end

    // Stage D: byte addresses, output register
    logic              m_valid_reg;
    out_word_t         m_data_reg;
    logic [ADDR_W-1:0] s_ext, d_ext;

    assign s_ext   = ADDR_W'(c_slin_reg);
    assign d_ext   = ADDR_W'(c_dlin_reg);
    assign d_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (d_ready) begin
            m_valid_reg <= c_valid_reg;
        end
        if (d_ready) begin
            m_data_reg.src_col        <= c_sc_reg;
            m_data_reg.src_row        <= c_sr_reg;
            m_data_reg.src_byte_addr  <= (s_ext << 1) + s_ext;
            m_data_reg.dest_byte_addr <= (d_ext << 1) + d_ext;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Source coordinates always land inside the source image
    a_col_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.src_col} < sw_reg))
        else $error("src_col outside source width");

    a_row_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.src_row} < sh_reg))
        else $error("src_row outside source height");

    // Input back-pressure only when every stage up to the output is full
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && a_valid_reg && c_valid_reg))
        else $error("input stalled with a bubble in the pipeline");

    // A held result keeps its addresses
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data_reg))
        else $error("output register changed under stall");

endmodule
